[rtl/adsr_pkg.sv]
// Shared widths, types and register codes for the ADSR envelope block.
// No dependencies; adsr_out_if and the top module import this package.
package adsr_pkg;

  localparam int TIME_W    = 24;
  localparam int LVL_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = TIME_W + LVL_W;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [NUM_W-1:0]  num_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_PEAK    = 3'd4
  } cfg_idx_t;

  localparam time_t  ATTACK_RST  = 24'd4800;
  localparam time_t  DECAY_RST   = 24'd4800;
  localparam time_t  RELEASE_RST = 24'd9600;
  localparam level_t SUSTAIN_RST = 16'd32768;
  localparam level_t PEAK_RST    = 16'd32768;

endpackage

[rtl/adsr_in_if.sv]
// Input channel of the envelope block: valid/ready plus the three tick fields.
// Tick width follows the TICK_BITS parameter.
interface adsr_in_if #(parameter int TICK_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] now_tick;
  logic [TICK_BITS-1:0] on_tick;
  logic [TICK_BITS-1:0] off_tick;

  modport source(output valid, now_tick, on_tick, off_tick, input ready);
  modport sink(input valid, now_tick, on_tick, off_tick, output ready);
endinterface

[rtl/adsr_out_if.sv]
// Result channel of the envelope block: valid/ready plus the amplitude.
// Depends on adsr_pkg for the level type.
interface adsr_out_if;
  import adsr_pkg::*;
  logic   valid;
  logic   ready;
  level_t amplitude;

  modport source(output valid, amplitude, input ready);
  modport sink(input valid, amplitude, output ready);
endinterface

[rtl/adsr_envelope_amplitude_top.sv]
// Linear ADSR envelope amplitude: tick differences in, Q1.15 level out.
// Depends on adsr_pkg, adsr_in_if, adsr_out_if, adsr_pipe_reg, adsr_div_chain.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        now_tick, on_tick, off_tick
//   out_ch    out        valid/ready        amplitude
//   cfg_*     in         cfg_we (no wait)   cfg_idx, cfg_wdata
//
// One item per cycle while out_ch.ready stays high; pipeline: 3 front stages, a 16-cell divider
// for the attack/decay level, 2 stages, a 16-cell divider for the release
// fraction and the output register. Each stage holds when the next one is
// full and stalled, so bubbles close up under backpressure.
// Reset (synchronous) empties the pipeline and loads the register defaults.
module adsr_envelope_amplitude_top #(
  parameter int TICK_BITS       = 32,
  parameter int LEVEL_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adsr_in_if.sink                       in_ch,
  adsr_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [adsr_pkg::CFG_W-1:0]     cfg_wdata
);

  import adsr_pkg::*;

  localparam int CMP_W = (TICK_BITS > TIME_W + 1) ? TICK_BITS : TIME_W + 1;
  localparam logic [31:0] LvlOne = 32'(1) << LEVEL_FRAC_BITS;

  localparam int S1_W   = 1 + 2 * TICK_BITS;
  localparam int S2_W   = 1 + TICK_BITS + TIME_W + LVL_W + TIME_W + LVL_W + 1;
  localparam int SIDE1_W = 1 + TICK_BITS + LVL_W + 1;
  localparam int S4_W   = 1 + TICK_BITS + LVL_W;
  localparam int SIDE2_W = LVL_W + 1;

  // ---------------------------------------------------------------- config
  time_t  attack_r, decay_r, release_r;
  level_t sustain_r, peak_r;

  function automatic time_t dur_fix(input time_t t);
    dur_fix = (t == '0) ? time_t'(1) : t;
  endfunction

  function automatic level_t lvl_fix(input level_t v);
    lvl_fix = (32'(v) > LvlOne) ? LVL_W'(LvlOne) : v;
  endfunction

  // Store durations and levels already fixed up, as they are used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      decay_r   <= DECAY_RST;
      release_r <= RELEASE_RST;
      sustain_r <= lvl_fix(SUSTAIN_RST);
      peak_r    <= lvl_fix(PEAK_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ATTACK:  attack_r  <= dur_fix(cfg_wdata[TIME_W-1:0]);
        CFG_DECAY:   decay_r   <= dur_fix(cfg_wdata[TIME_W-1:0]);
        CFG_RELEASE: release_r <= dur_fix(cfg_wdata[TIME_W-1:0]);
        CFG_SUSTAIN: sustain_r <= lvl_fix(cfg_wdata[LVL_W-1:0]);
        CFG_PEAK:    peak_r    <= lvl_fix(cfg_wdata[LVL_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                 s1i_held;
  logic [TICK_BITS-1:0] s1i_life, s1i_r;

  always_comb begin
    s1i_held = in_ch.on_tick > in_ch.off_tick;
    s1i_life = s1i_held ? in_ch.now_tick - in_ch.on_tick
                        : in_ch.off_tick - in_ch.on_tick;
    s1i_r    = in_ch.now_tick - in_ch.off_tick;
  end

  logic                 s1_valid, s1_ready;
  logic                 s1_held;
  logic [TICK_BITS-1:0] s1_life, s1_r;

  adsr_pipe_reg #(.W(S1_W)) u_s1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  ({s1i_held, s1i_life, s1i_r}),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  ({s1_held, s1_life, s1_r})
  );

  // ---------------------------------------------------------------- stage 2
  // Pick the segment: level = base +/- (ma * mb) / den.
  logic [CMP_W-1:0] life_x, a_x, ad_x;
  time_t            s2i_ma, s2i_den, dt;
  level_t           s2i_mb, s2i_base;
  logic             s2i_neg;

  always_comb begin
    life_x = CMP_W'(s1_life);
    a_x    = CMP_W'(attack_r);
    ad_x   = CMP_W'(attack_r) + CMP_W'(decay_r);
    dt     = TIME_W'(life_x - a_x);
    priority if (life_x <= a_x) begin
      s2i_ma   = TIME_W'(life_x);
      s2i_mb   = peak_r;
      s2i_den  = attack_r;
      s2i_base = '0;
      s2i_neg  = 1'b0;
    end else if (life_x <= ad_x) begin
      s2i_ma   = dt;
      s2i_mb   = (sustain_r >= peak_r) ? sustain_r - peak_r : peak_r - sustain_r;
      s2i_den  = decay_r;
      s2i_base = peak_r;
      s2i_neg  = sustain_r < peak_r;
    end else begin
      s2i_ma   = '0;
      s2i_mb   = '0;
      s2i_den  = decay_r;
      s2i_base = sustain_r;
      s2i_neg  = 1'b0;
    end
  end

  logic                 s2_valid, s2_ready;
  logic                 s2_held;
  logic [TICK_BITS-1:0] s2_r;
  time_t                s2_ma, s2_den;
  level_t               s2_mb, s2_base;
  logic                 s2_neg;

  adsr_pipe_reg #(.W(S2_W)) u_s2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  ({s1_held, s1_r, s2i_ma, s2i_mb, s2i_den, s2i_base, s2i_neg}),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  ({s2_held, s2_r, s2_ma, s2_mb, s2_den, s2_base, s2_neg})
  );

  // ---------------------------------------------------------------- stage 3
  num_t s3i_num;
  assign s3i_num = num_t'(s2_ma) * num_t'(s2_mb);

  logic                 s3_valid, s3_ready;
  logic [SIDE1_W-1:0]   s3_side;
  time_t                s3_den;
  num_t                 s3_num;

  adsr_pipe_reg #(.W(SIDE1_W + TIME_W + NUM_W)) u_s3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  ({s2_held, s2_r, s2_base, s2_neg, s2_den, s3i_num}),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  ({s3_side, s3_den, s3_num})
  );

  // ------------------------------------------------------- level divider
  logic                 d1_valid, d1_ready;
  num_t                 d1_acc;
  logic                 d1_held, d1_neg;
  logic [TICK_BITS-1:0] d1_r;
  level_t               d1_base;

  adsr_div_chain #(.DEN_W(TIME_W), .Q_W(LVL_W), .SIDE_W(SIDE1_W)) u_div_lvl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_acc   (s3_num),
    .up_den   (s3_den),
    .up_side  (s3_side),
    .dn_valid (d1_valid),
    .dn_ready (d1_ready),
    .dn_acc   (d1_acc),
    .dn_side  ({d1_held, d1_r, d1_base, d1_neg})
  );

  // ---------------------------------------------------------------- stage 4
  level_t s4i_level;
  assign s4i_level = d1_neg ? d1_base - d1_acc[LVL_W-1:0] : d1_base + d1_acc[LVL_W-1:0];

  logic                 s4_valid, s4_ready;
  logic                 s4_held;
  logic [TICK_BITS-1:0] s4_r;
  level_t               s4_level;

  adsr_pipe_reg #(.W(S4_W)) u_s4 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d1_valid),
    .up_ready (d1_ready),
    .up_data  ({d1_held, d1_r, s4i_level}),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_data  ({s4_held, s4_r, s4_level})
  );

  // ---------------------------------------------------------------- stage 5
  // Released: amplitude = rl - r * rl / release, or zero past the release; held: level passes.
  logic [CMP_W-1:0] r_x;
  logic             s5i_zero;
  time_t            s5i_ma;
  level_t           s5i_mb;
  num_t             s5i_num;

  always_comb begin
    r_x      = CMP_W'(s4_r);
    s5i_zero = !s4_held && (r_x >= CMP_W'(release_r));
    s5i_ma   = (s4_held || s5i_zero) ? '0 : TIME_W'(r_x);
    s5i_mb   = s4_held ? '0 : s4_level;
    s5i_num  = num_t'(s5i_ma) * num_t'(s5i_mb);
  end

  logic               s5_valid, s5_ready;
  logic [SIDE2_W-1:0] s5_side;
  time_t              s5_den;
  num_t               s5_num;

  adsr_pipe_reg #(.W(SIDE2_W + TIME_W + NUM_W)) u_s5 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s4_valid),
    .up_ready (s4_ready),
    .up_data  ({s4_level, s5i_zero, release_r, s5i_num}),
    .dn_valid (s5_valid),
    .dn_ready (s5_ready),
    .dn_data  ({s5_side, s5_den, s5_num})
  );

  // ----------------------------------------------------- release divider
  logic   d2_valid, d2_ready;
  num_t   d2_acc;
  level_t d2_base;
  logic   d2_zero;

  adsr_div_chain #(.DEN_W(TIME_W), .Q_W(LVL_W), .SIDE_W(SIDE2_W)) u_div_rel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s5_valid),
    .up_ready (s5_ready),
    .up_acc   (s5_num),
    .up_den   (s5_den),
    .up_side  (s5_side),
    .dn_valid (d2_valid),
    .dn_ready (d2_ready),
    .dn_acc   (d2_acc),
    .dn_side  ({d2_base, d2_zero})
  );

  // ---------------------------------------------------------------- output
  level_t amp;
  assign amp = d2_zero ? '0 : d2_base - d2_acc[LVL_W-1:0];

  adsr_pipe_reg #(.W(LVL_W)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d2_valid),
    .up_ready (d2_ready),
    .up_data  (amp),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_ch.amplitude)
  );

endmodule

[rtl/adsr_pipe_reg.sv]
// One valid/ready register stage; the stage takes a new item whenever it is
// empty or its content leaves in the same cycle. No dependencies.
module adsr_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= up_data;
    end
  end

endmodule

[rtl/adsr_div_cell.sv]
// One restoring-division cell: resolves one quotient bit and hands the
// partial remainder on. Depends on adsr_pipe_reg.
module adsr_div_cell #(
  parameter int DEN_W  = 24,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [DEN_W+Q_W-1:0]   up_acc,
  input  logic [DEN_W-1:0]       up_den,
  input  logic [SIDE_W-1:0]      up_side,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [DEN_W+Q_W-1:0]   dn_acc,
  output logic [DEN_W-1:0]       dn_den,
  output logic [SIDE_W-1:0]      dn_side
);

  localparam int ACC_W = DEN_W + Q_W;
  localparam int W     = SIDE_W + DEN_W + ACC_W;

  logic [ACC_W:0]   shifted;
  logic [DEN_W:0]   part;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem;
  logic [ACC_W-1:0] acc_nxt;

  // Upper field holds the remainder, lower field collects quotient bits.
  always_comb begin
    shifted = {up_acc, 1'b0};
    part    = shifted[ACC_W:Q_W];
    diff    = part - {1'b0, up_den};
    fits    = part >= {1'b0, up_den};
    rem     = fits ? diff[DEN_W-1:0] : part[DEN_W-1:0];
    acc_nxt = {rem, shifted[Q_W-1:1], fits};
  end

  adsr_pipe_reg #(.W(W)) u_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (up_valid),
    .up_ready (up_ready),
    .up_data  ({up_side, up_den, acc_nxt}),
    .dn_valid (dn_valid),
    .dn_ready (dn_ready),
    .dn_data  ({dn_side, dn_den, dn_acc})
  );

endmodule

[rtl/adsr_div_chain.sv]
// Row of Q_W division cells: one quotient bit per cell, one item per cycle unless dn_ready stalls.
// The numerator must be below den * 2^Q_W. Depends on adsr_div_cell.
module adsr_div_chain #(
  parameter int DEN_W  = 24,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [DEN_W+Q_W-1:0]   up_acc,
  input  logic [DEN_W-1:0]       up_den,
  input  logic [SIDE_W-1:0]      up_side,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [DEN_W+Q_W-1:0]   dn_acc,
  output logic [SIDE_W-1:0]      dn_side
);

  localparam int ACC_W = DEN_W + Q_W;

  logic [Q_W:0]        vld;
  logic [Q_W:0]        rdy;
  logic [ACC_W-1:0]    acc  [Q_W+1];
  logic [DEN_W-1:0]    den  [Q_W+1];
  logic [SIDE_W-1:0]   side [Q_W+1];

  assign vld[0]   = up_valid;
  assign up_ready = rdy[0];
  assign acc[0]   = up_acc;
  assign den[0]   = up_den;
  assign side[0]  = up_side;

  assign dn_valid = vld[Q_W];
  assign rdy[Q_W] = dn_ready;
  assign dn_acc   = acc[Q_W];
  assign dn_side  = side[Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    adsr_div_cell #(.DEN_W(DEN_W), .Q_W(Q_W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_acc   (acc[i]),
      .up_den   (den[i]),
      .up_side  (side[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_acc   (acc[i+1]),
      .dn_den   (den[i+1]),
      .dn_side  (side[i+1])
    );
  end

endmodule
